FILE: rtl/core/qvr_pkg.sv
//------------------------------------------------------------------------------
// qvr_pkg
// Shared types, widths and constants for the quaternion vector rotator.
//------------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

    // Parameter defaults
    localparam int COORD_WIDTH_DEF = 32;
    localparam int TRIG_STEPS_DEF  = 16;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE  = 3'd0,
        CFG_AXIS_X = 3'd1,
        CFG_AXIS_Y = 3'd2,
        CFG_AXIS_Z = 3'd3
    } t_cfg_reg;

    localparam logic signed [CFG_W-1:0] ANGLE_RESET = 16'sd4096;

    // Matrix coefficients, signed Q1.16
    localparam int COEF_W = 18;
    typedef logic signed [COEF_W-1:0] t_coef;
    localparam t_coef ONE_Q16 = 18'sd65536;

    // Builder datapath widths
    localparam int H_W    = 36;   // half angle, Q2.30 with headroom
    localparam int C_W    = 32;   // CORDIC x/y
    localparam int Q_W    = 48;   // raw quaternion terms
    localparam int S_W    = 24;   // normalized quaternion terms
    localparam int P_W    = 46;   // products of normalized terms
    localparam int DIV_W  = 64;   // divider dividend
    localparam int QUO_W  = 18;   // divider quotient
    localparam int ATAN_W = 31;
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [H_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [H_W-1:0] HALF_PI_Q30 = 36'sd1686629713;

    // Matrix builder states
    typedef enum logic [3:0] {
        BLD_IDLE,
        BLD_INIT,
        BLD_CORDIC,
        BLD_MUL,
        BLD_MAX,
        BLD_NORM,
        BLD_PROD,
        BLD_SUM,
        BLD_DIV_GO,
        BLD_DIV_WAIT
    } t_bld_state;

    // Divider request / response
    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] dividend;
        logic [P_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    // arctan(2^-i) in Q2.30
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:  v = 31'd843314857;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043837;
            5'd3:  v = 31'd133525159;
            5'd4:  v = 31'd67021687;
            5'd5:  v = 31'd33543516;
            5'd6:  v = 31'd16775851;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194283;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048576;
            5'd11: v = 31'd524288;
            5'd12: v = 31'd262144;
            5'd13: v = 31'd131072;
            5'd14: v = 31'd65536;
            5'd15: v = 31'd32768;
            5'd16: v = 31'd16384;
            5'd17: v = 31'd8192;
            5'd18: v = 31'd4096;
            5'd19: v = 31'd2048;
            5'd20: v = 31'd1024;
            5'd21: v = 31'd512;
            5'd22: v = 31'd256;
            5'd23: v = 31'd128;
            5'd24: v = 31'd64;
            5'd25: v = 31'd32;
            5'd26: v = 31'd16;
            5'd27: v = 31'd8;
            5'd28: v = 31'd4;
            5'd29: v = 31'd2;
            5'd30: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qvr_div.sv
//------------------------------------------------------------------------------
// qvr_div
// Restoring divider, one quotient bit per cycle. Quotient known < 2^QUO_W.
//------------------------------------------------------------------------------
`default_nettype none

module qvr_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire qvr_pkg::t_div_req i_req,
    output qvr_pkg::t_div_rsp      o_rsp
);

    localparam int DW = qvr_pkg::DIV_W;
    localparam int QW = qvr_pkg::QUO_W;
    localparam logic [4:0] LAST = 5'(QW - 1);

    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic [QW-1:0] r_quo, n_quo;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_run, n_run;
    logic          r_done, n_done;
    logic          fits;

    assign fits = (r_rem >= r_den);

    // next-state for one subtract-and-shift step
    always_comb begin
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_req.go) begin
            n_rem = i_req.dividend;
            n_den = {{(DW - qvr_pkg::P_W){1'b0}}, i_req.divisor} << (QW - 1);
            n_quo = '0;
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (fits) begin
                n_rem = r_rem - r_den;
            end
            n_quo = {r_quo[QW-2:0], fits};
            n_den = r_den >> 1;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == LAST) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

FILE: rtl/core/qvr_build.sv
//------------------------------------------------------------------------------
// qvr_build
// Configuration registers and the sequencer that rebuilds the rotation
// matrix: CORDIC, quaternion scaling, products and nine divisions.
//------------------------------------------------------------------------------
`default_nettype none

module qvr_build #(
    parameter int TRIG_STEPS = qvr_pkg::TRIG_STEPS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [qvr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [qvr_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  wire qvr_pkg::t_div_rsp                   i_div_rsp,
    output qvr_pkg::t_div_req                        o_div_req,
    output qvr_pkg::t_coef                           o_mat [9],
    output logic                                     o_norm_zero,
    output logic                                     o_busy
);

    localparam int H_W  = qvr_pkg::H_W;
    localparam int C_W  = qvr_pkg::C_W;
    localparam int Q_W  = qvr_pkg::Q_W;
    localparam int S_W  = qvr_pkg::S_W;
    localparam int P_W  = qvr_pkg::P_W;
    localparam int DW   = qvr_pkg::DIV_W;
    localparam int QW   = qvr_pkg::QUO_W;
    localparam logic [4:0] CORDIC_LAST = 5'(TRIG_STEPS - 1);

    // product slots
    localparam logic [3:0] P_WW = 4'd0;
    localparam logic [3:0] P_XX = 4'd1;
    localparam logic [3:0] P_YY = 4'd2;
    localparam logic [3:0] P_ZZ = 4'd3;
    localparam logic [3:0] P_XY = 4'd4;
    localparam logic [3:0] P_WZ = 4'd5;
    localparam logic [3:0] P_XZ = 4'd6;
    localparam logic [3:0] P_WY = 4'd7;
    localparam logic [3:0] P_YZ = 4'd8;
    localparam logic [3:0] P_WX = 4'd9;

    localparam logic [Q_W-1:0] M_HI = Q_W'(64'd1 << 21);
    localparam logic [Q_W-1:0] M_LO = Q_W'(64'd1 << 20);

    qvr_pkg::t_bld_state r_state, n_state;

    logic signed [15:0]    r_angle, n_angle, r_ax, n_ax, r_ay, n_ay, r_az, n_az;
    logic signed [H_W-1:0] r_h, n_h;
    logic signed [C_W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [4:0]            r_cnt, n_cnt;
    logic signed [Q_W-1:0] r_q [4];
    logic signed [Q_W-1:0] n_q [4];
    logic [Q_W-1:0]        r_m, n_m;
    logic signed [P_W-1:0] r_pr [10];
    logic signed [P_W-1:0] n_pr [10];
    logic [P_W-1:0]        r_n2, n_n2;
    logic [3:0]            r_ent, n_ent;
    logic                  r_neg, n_neg;
    qvr_pkg::t_coef        r_mat [9];
    qvr_pkg::t_coef        n_mat [9];
    logic                  r_norm_zero, n_norm_zero;

    // helpers
    logic signed [H_W-1:0] h0, h_fold, atan_e;
    logic signed [C_W-1:0] xs, ys;
    logic signed [Q_W-1:0] cy_e, ax_e, ay_e, az_e;
    logic [Q_W-1:0]        a0, a1, a2, a3, m01, m23, m_all;
    logic signed [S_W-1:0] s0, s1, s2, s3, pa, pb;
    logic signed [P_W-1:0] pa_e, pb_e, pm;
    logic signed [P_W:0]   pr_e [10];
    logic signed [P_W:0]   combo;
    logic [P_W:0]          mag;
    logic signed [QW:0]    qv, qs, ent_v;
    logic                  diag;

    // half angle, folded into [-pi/2, pi/2]
    assign h0 = {{(H_W - 33){r_angle[15]}}, r_angle, 17'b0};
    always_comb begin
        if (h0 > qvr_pkg::HALF_PI_Q30) begin
            h_fold = h0 - qvr_pkg::PI_Q30;
        end else if (h0 < -qvr_pkg::HALF_PI_Q30) begin
            h_fold = h0 + qvr_pkg::PI_Q30;
        end else begin
            h_fold = h0;
        end
    end

    // CORDIC step terms
    assign atan_e = {{(H_W - qvr_pkg::ATAN_W){1'b0}}, qvr_pkg::atan_q30(r_cnt)};
    assign xs     = r_cx >>> r_cnt;
    assign ys     = r_cy >>> r_cnt;

    // sin times axis
    assign cy_e = {{(Q_W - C_W){r_cy[C_W-1]}}, r_cy};
    assign ax_e = {{(Q_W - 16){r_ax[15]}}, r_ax};
    assign ay_e = {{(Q_W - 16){r_ay[15]}}, r_ay};
    assign az_e = {{(Q_W - 16){r_az[15]}}, r_az};

    // largest magnitude
    assign a0    = r_q[0][Q_W-1] ? Q_W'(-r_q[0]) : r_q[0];
    assign a1    = r_q[1][Q_W-1] ? Q_W'(-r_q[1]) : r_q[1];
    assign a2    = r_q[2][Q_W-1] ? Q_W'(-r_q[2]) : r_q[2];
    assign a3    = r_q[3][Q_W-1] ? Q_W'(-r_q[3]) : r_q[3];
    assign m01   = (a0 > a1) ? a0 : a1;
    assign m23   = (a2 > a3) ? a2 : a3;
    assign m_all = (m01 > m23) ? m01 : m23;

    // normalized terms and one product per cycle
    assign s0 = r_q[0][S_W-1:0];
    assign s1 = r_q[1][S_W-1:0];
    assign s2 = r_q[2][S_W-1:0];
    assign s3 = r_q[3][S_W-1:0];

    always_comb begin
        case (r_cnt[3:0])
            P_WW:    begin pa = s0; pb = s0; end
            P_XX:    begin pa = s1; pb = s1; end
            P_YY:    begin pa = s2; pb = s2; end
            P_ZZ:    begin pa = s3; pb = s3; end
            P_XY:    begin pa = s1; pb = s2; end
            P_WZ:    begin pa = s0; pb = s3; end
            P_XZ:    begin pa = s1; pb = s3; end
            P_WY:    begin pa = s0; pb = s2; end
            P_YZ:    begin pa = s2; pb = s3; end
            P_WX:    begin pa = s0; pb = s1; end
            default: begin pa = '0; pb = '0; end
        endcase
    end
    assign pa_e = {{(P_W - S_W){pa[S_W-1]}}, pa};
    assign pb_e = {{(P_W - S_W){pb[S_W-1]}}, pb};
    assign pm   = pa_e * pb_e;

    // numerator of the current matrix entry
    always_comb begin
        for (int i = 0; i < 10; i++) begin
            pr_e[i] = {r_pr[i][P_W-1], r_pr[i]};
        end
    end

    always_comb begin
        case (r_ent)
            4'd0:    combo = pr_e[P_YY] + pr_e[P_ZZ];
            4'd1:    combo = pr_e[P_XY] - pr_e[P_WZ];
            4'd2:    combo = pr_e[P_XZ] + pr_e[P_WY];
            4'd3:    combo = pr_e[P_XY] + pr_e[P_WZ];
            4'd4:    combo = pr_e[P_XX] + pr_e[P_ZZ];
            4'd5:    combo = pr_e[P_YZ] - pr_e[P_WX];
            4'd6:    combo = pr_e[P_XZ] - pr_e[P_WY];
            4'd7:    combo = pr_e[P_YZ] + pr_e[P_WX];
            4'd8:    combo = pr_e[P_XX] + pr_e[P_YY];
            default: combo = '0;
        endcase
    end
    assign mag  = combo[P_W] ? (P_W + 1)'(-combo) : combo;
    assign diag = (r_ent == 4'd0) || (r_ent == 4'd4) || (r_ent == 4'd8);

    // rounded quotient back to a coefficient
    assign qv    = {1'b0, i_div_rsp.quo};
    assign qs    = r_neg ? -qv : qv;
    assign ent_v = diag ? ((QW + 1)'(qvr_pkg::ONE_Q16) - qs) : qs;

    // divider request: round half away from zero via n2/2 bias
    assign o_div_req.go       = (r_state == qvr_pkg::BLD_DIV_GO);
    assign o_div_req.dividend = {mag, 17'b0} + {{(DW - P_W + 1){1'b0}}, r_n2[P_W-1:1]};
    assign o_div_req.divisor  = r_n2;

    // sequencer: next state and datapath
    always_comb begin
        n_state     = r_state;
        n_angle     = r_angle;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_az        = r_az;
        n_h         = r_h;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cnt       = r_cnt;
        n_m         = r_m;
        n_n2        = r_n2;
        n_ent       = r_ent;
        n_neg       = r_neg;
        n_norm_zero = r_norm_zero;
        for (int i = 0; i < 4; i++) begin
            n_q[i] = r_q[i];
        end
        for (int i = 0; i < 10; i++) begin
            n_pr[i] = r_pr[i];
        end
        for (int i = 0; i < 9; i++) begin
            n_mat[i] = r_mat[i];
        end

        case (r_state)
            qvr_pkg::BLD_IDLE: begin
            end
            qvr_pkg::BLD_INIT: begin
                n_h     = h_fold;
                n_cx    = C_W'(64'd1 << 29);
                n_cy    = '0;
                n_cnt   = '0;
                n_state = qvr_pkg::BLD_CORDIC;
            end
            qvr_pkg::BLD_CORDIC: begin
                if (!r_h[H_W-1]) begin
                    n_cx = r_cx - ys;
                    n_cy = r_cy + xs;
                    n_h  = r_h - atan_e;
                end else begin
                    n_cx = r_cx + ys;
                    n_cy = r_cy - xs;
                    n_h  = r_h + atan_e;
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == CORDIC_LAST) begin
                    n_state = qvr_pkg::BLD_MUL;
                end
            end
            qvr_pkg::BLD_MUL: begin
                n_q[0]  = {{(Q_W - C_W - 12){r_cx[C_W-1]}}, r_cx, 12'b0};
                n_q[1]  = cy_e * ax_e;
                n_q[2]  = cy_e * ay_e;
                n_q[3]  = cy_e * az_e;
                n_state = qvr_pkg::BLD_MAX;
            end
            qvr_pkg::BLD_MAX: begin
                n_m = m_all;
                if (m_all == '0) begin
                    // all-zero quaternion: fall back to identity
                    for (int i = 0; i < 9; i++) begin
                        n_mat[i] = ((i % 4) == 0) ? qvr_pkg::ONE_Q16 : '0;
                    end
                    n_norm_zero = 1'b1;
                    n_state     = qvr_pkg::BLD_IDLE;
                end else begin
                    n_state = qvr_pkg::BLD_NORM;
                end
            end
            qvr_pkg::BLD_NORM: begin
                // bring largest magnitude into [2^20, 2^21)
                if (r_m >= M_HI) begin
                    for (int i = 0; i < 4; i++) begin
                        n_q[i] = r_q[i] >>> 1;
                    end
                    n_m = r_m >> 1;
                end else if (r_m < M_LO) begin
                    for (int i = 0; i < 4; i++) begin
                        n_q[i] = r_q[i] <<< 1;
                    end
                    n_m = r_m << 1;
                end else begin
                    n_norm_zero = 1'b0;
                    n_cnt       = '0;
                    n_state     = qvr_pkg::BLD_PROD;
                end
            end
            qvr_pkg::BLD_PROD: begin
                n_pr[r_cnt[3:0]] = pm;
                n_cnt            = r_cnt + 5'd1;
                if (r_cnt[3:0] == P_WX) begin
                    n_state = qvr_pkg::BLD_SUM;
                end
            end
            qvr_pkg::BLD_SUM: begin
                n_n2    = r_pr[P_WW] + r_pr[P_XX] + r_pr[P_YY] + r_pr[P_ZZ];
                n_ent   = '0;
                n_state = qvr_pkg::BLD_DIV_GO;
            end
            qvr_pkg::BLD_DIV_GO: begin
                n_neg   = combo[P_W];
                n_state = qvr_pkg::BLD_DIV_WAIT;
            end
            qvr_pkg::BLD_DIV_WAIT: begin
                if (i_div_rsp.done) begin
                    n_mat[r_ent] = ent_v[qvr_pkg::COEF_W-1:0];
                    n_ent        = r_ent + 4'd1;
                    if (r_ent == 4'd8) begin
                        n_state = qvr_pkg::BLD_IDLE;
                    end else begin
                        n_state = qvr_pkg::BLD_DIV_GO;
                    end
                end
            end
            default: begin
                n_state = qvr_pkg::BLD_IDLE;
            end
        endcase

        // register write restarts the rebuild from all four registers
        if (i_cfg_we) begin
            case (i_cfg_idx)
                qvr_pkg::CFG_ANGLE: begin
                    n_angle = i_cfg_wdata;
                    n_state = qvr_pkg::BLD_INIT;
                end
                qvr_pkg::CFG_AXIS_X: begin
                    n_ax    = i_cfg_wdata;
                    n_state = qvr_pkg::BLD_INIT;
                end
                qvr_pkg::CFG_AXIS_Y: begin
                    n_ay    = i_cfg_wdata;
                    n_state = qvr_pkg::BLD_INIT;
                end
                qvr_pkg::CFG_AXIS_Z: begin
                    n_az    = i_cfg_wdata;
                    n_state = qvr_pkg::BLD_INIT;
                end
                default: begin
                end
            endcase
        end
    end

    // state, config and matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qvr_pkg::BLD_IDLE;
            r_angle     <= qvr_pkg::ANGLE_RESET;
            r_ax        <= '0;
            r_ay        <= '0;
            r_az        <= '0;
            r_norm_zero <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_mat[i] <= ((i % 4) == 0) ? qvr_pkg::ONE_Q16 : '0;
            end
        end else begin
            r_state     <= n_state;
            r_angle     <= n_angle;
            r_ax        <= n_ax;
            r_ay        <= n_ay;
            r_az        <= n_az;
            r_norm_zero <= n_norm_zero;
            for (int i = 0; i < 9; i++) begin
                r_mat[i] <= n_mat[i];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_h   <= n_h;
        r_cx  <= n_cx;
        r_cy  <= n_cy;
        r_cnt <= n_cnt;
        r_m   <= n_m;
        r_n2  <= n_n2;
        r_ent <= n_ent;
        r_neg <= n_neg;
        for (int i = 0; i < 4; i++) begin
            r_q[i] <= n_q[i];
        end
        for (int i = 0; i < 10; i++) begin
            r_pr[i] <= n_pr[i];
        end
    end

    assign o_mat       = r_mat;
    assign o_norm_zero = r_norm_zero;
    assign o_busy      = (r_state != qvr_pkg::BLD_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/qvr_rotate.sv
//------------------------------------------------------------------------------
// qvr_rotate
// Three-stage point pipeline: input register, nine products, row sums with
// rounding and saturation into the result register.
//------------------------------------------------------------------------------
`default_nettype none

module qvr_rotate #(
    parameter int COORD_WIDTH = qvr_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_go,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  wire qvr_pkg::t_coef                i_mat [9],
    input  wire logic                          i_degen,
    output logic                               o_strobe,
    output logic signed [COORD_WIDTH-1:0]      o_rot_x,
    output logic signed [COORD_WIDTH-1:0]      o_rot_y,
    output logic signed [COORD_WIDTH-1:0]      o_rot_z,
    output logic                               o_degenerate
);

    localparam int W  = COORD_WIDTH;
    localparam int CW = qvr_pkg::COEF_W;
    localparam int MW = CW + W;
    localparam int SW = MW + 2;

    logic                 r_v1, r_v2, r_v3;
    logic                 r_d1, r_d2, r_d3;
    logic signed [W-1:0]  r_p [3];
    logic signed [MW-1:0] r_pm [9];
    logic signed [W-1:0]  r_rot [3];
    logic signed [MW-1:0] ce [9];
    logic signed [MW-1:0] pe [3];
    logic signed [SW-1:0] s [3];
    logic signed [SW-1:0] sh [3];
    logic signed [W-1:0]  n_rot [3];

    // operand extension
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            ce[k] = {{W{i_mat[k][CW-1]}}, i_mat[k]};
        end
        for (int j = 0; j < 3; j++) begin
            pe[j] = {{CW{r_p[j][W-1]}}, r_p[j]};
        end
    end

    // row sum, round half up at bit 16, saturate
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            s[r] = {{2{r_pm[3*r][MW-1]}},   r_pm[3*r]}
                 + {{2{r_pm[3*r+1][MW-1]}}, r_pm[3*r+1]}
                 + {{2{r_pm[3*r+2][MW-1]}}, r_pm[3*r+2]}
                 + SW'(32768);
            sh[r] = s[r] >>> 16;
            if ((&sh[r][SW-1:W-1]) || !(|sh[r][SW-1:W-1])) begin
                n_rot[r] = sh[r][W-1:0];
            end else if (sh[r][SW-1]) begin
                n_rot[r] = {1'b1, {(W-1){1'b0}}};
            end else begin
                n_rot[r] = {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    // request valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_go;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_p[0] <= i_pos_x;
            r_p[1] <= i_pos_y;
            r_p[2] <= i_pos_z;
            r_d1   <= i_degen;
        end
        r_d2 <= r_d1;
        r_d3 <= r_d2;
        for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
                r_pm[3*r+j] <= ce[3*r+j] * pe[j];
            end
            r_rot[r] <= n_rot[r];
        end
    end

    assign o_strobe     = r_v3;
    assign o_rot_x      = r_rot[0];
    assign o_rot_y      = r_rot[1];
    assign o_rot_z      = r_rot[2];
    assign o_degenerate = r_d3;

endmodule

`default_nettype wire

FILE: rtl/core/quaternion_vector_rotate.sv
//------------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates Q16.16 points by a cached Q1.16 matrix built from an angle/axis
// quaternion held in configuration registers.
//------------------------------------------------------------------------------
// A request taken at start && !busy passes the input, product and result
// registers before it shows on o_strobe. Throughput: one point per cycle
// while not busy, through the 3-stage product/sum pipeline. busy rises after
// a write to one of the four registers while the matrix is rebuilt: CORDIC,
// scaling, 10 products, then nine divisions in one shared divider.
// Reset: identity matrix, degenerate flag in the builder clear, no clearing pass.
//------------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotate #(
    parameter int COORD_WIDTH = qvr_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_STEPS  = qvr_pkg::TRIG_STEPS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0]       i_pos_z,
    output logic                                     o_strobe,
    output logic signed [COORD_WIDTH-1:0]            o_rot_x,
    output logic signed [COORD_WIDTH-1:0]            o_rot_y,
    output logic signed [COORD_WIDTH-1:0]            o_rot_z,
    output logic                                     o_degenerate,
    input  wire logic                                i_cfg_we,
    input  wire logic [qvr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [qvr_pkg::CFG_W-1:0]           i_cfg_wdata
);

    qvr_pkg::t_div_req div_req;
    qvr_pkg::t_div_rsp div_rsp;
    qvr_pkg::t_coef    mat [9];
    logic              norm_zero;
    logic              accept;

    assign accept = start && !busy;

    // shared divider for matrix coefficients
    qvr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // config registers and matrix rebuild
    qvr_build #(
        .TRIG_STEPS (TRIG_STEPS)
    ) u_build (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_div_rsp   (div_rsp),
        .o_div_req   (div_req),
        .o_mat       (mat),
        .o_norm_zero (norm_zero),
        .o_busy      (busy)
    );

    // point pipeline
    qvr_rotate #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_rotate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (accept),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_mat        (mat),
        .i_degen      (norm_zero),
        .o_strobe     (o_strobe),
        .o_rot_x      (o_rot_x),
        .o_rot_y      (o_rot_y),
        .o_rot_z      (o_rot_z),
        .o_degenerate (o_degenerate)
    );

    // every accepted request yields a result on o_strobe after the pipeline registers
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_strobe)
        else $error("accepted request produced no result");

    // no result without a request
    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 3))
        else $error("result without matching request");

    // a valid register write starts a rebuild
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == qvr_pkg::CFG_ANGLE || i_cfg_idx == qvr_pkg::CFG_AXIS_X
            || i_cfg_idx == qvr_pkg::CFG_AXIS_Y || i_cfg_idx == qvr_pkg::CFG_AXIS_Z))
        |=> busy)
        else $error("register write did not start matrix rebuild");

endmodule

`default_nettype wire
